@@ rtl/kt_pkg.sv @@
`default_nettype none

package kt_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int KEY_W         = 32;
    localparam int VAL_W         = 64;
    localparam int FILL_W        = 5;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_REMOVE = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_SCAN = 1'b1
    } t_state;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic load;   // write the new entry into the cell at the given position
        logic shift;  // every occupied cell below the tail takes its upper neighbor
        logic keep;   // on a shift, the head entry wraps to the tail
    } t_cell_ctl;

endpackage

`default_nettype wire

@@ rtl/kt_cell.sv @@
`default_nettype none

module kt_cell
    import kt_pkg::*;
#(
    parameter int CW  = 5,
    parameter int IDX = 0
) (
    input  wire logic             i_clk,
    input  wire t_cell_ctl        i_ctl,
    input  wire logic [CW-1:0]    i_pos,
    input  wire logic [KEY_W-1:0] i_new_key,
    input  wire logic [VAL_W-1:0] i_new_val,
    input  wire logic [KEY_W-1:0] i_next_key,
    input  wire logic [VAL_W-1:0] i_next_val,
    input  wire logic [KEY_W-1:0] i_head_key,
    input  wire logic [VAL_W-1:0] i_head_val,
    output logic      [KEY_W-1:0] o_key,
    output logic      [VAL_W-1:0] o_val
);

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_val;
    logic [KEY_W-1:0] n_key;
    logic [VAL_W-1:0] n_val;

    always_comb begin
        n_key = r_key;
        n_val = r_val;
        if (i_ctl.load && MY_IDX == i_pos) begin
            n_key = i_new_key;
            n_val = i_new_val;
        end else if (i_ctl.shift) begin
            // On a shift, i_pos names the current tail of the ring.
            if (MY_IDX < i_pos) begin
                n_key = i_next_key;
                n_val = i_next_val;
            end else if (MY_IDX == i_pos && i_ctl.keep) begin
                n_key = i_head_key;
                n_val = i_head_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_val <= n_val;
    end

    assign o_key = r_key;
    assign o_val = r_val;

endmodule

`default_nettype wire

@@ rtl/kt_ctrl.sv @@
`default_nettype none

module kt_ctrl
    import kt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [1:0]         i_cmd,
    input  wire logic [KEY_W-1:0]   i_key,
    input  wire logic [VAL_W-1:0]   i_value,
    input  wire logic [KEY_W-1:0]   i_head_key,
    input  wire logic [VAL_W-1:0]   i_head_val,
    output logic                    o_busy,
    output t_cell_ctl               o_ctl,
    output logic [CW-1:0]           o_pos,
    output logic                    o_valid,
    output logic [1:0]              o_status,
    output logic [KEY_W-1:0]        o_found_key,
    output logic [VAL_W-1:0]        o_found_value,
    output logic [FILL_W-1:0]       o_fill_count
);

    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    t_state           r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_left, n_left;
    logic [KEY_W-1:0] r_key, n_key;
    logic             r_remove, n_remove;
    logic             r_found, n_found;
    logic [KEY_W-1:0] r_fkey, n_fkey;
    logic [VAL_W-1:0] r_fval, n_fval;
    logic             r_valid, n_valid;
    logic [1:0]       r_status, n_status;
    logic [KEY_W-1:0] r_okey, n_okey;
    logic [VAL_W-1:0] r_oval, n_oval;
    logic [FILL_W-1:0] r_ofill, n_ofill;
    logic             hit;
    logic             accept;

    assign accept = i_start && r_state == S_IDLE;
    assign hit    = !r_found && i_head_key == r_key;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_left   = r_left;
        n_key    = r_key;
        n_remove = r_remove;
        n_found  = r_found;
        n_fkey   = r_fkey;
        n_fval   = r_fval;
        n_valid  = 1'b0;
        n_status = r_status;
        n_okey   = r_okey;
        n_oval   = r_oval;
        n_ofill  = r_ofill;
        o_ctl    = '0;
        o_pos    = r_count;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_cmd)
                        CMD_INSERT: begin
                            n_valid = 1'b1;
                            if (r_count < FULL_COUNT) begin
                                o_ctl.load = 1'b1;
                                n_count    = r_count + 1'b1;
                                n_status   = ST_OK;
                                n_okey     = i_key;
                                n_oval     = i_value;
                            end else begin
                                n_status = ST_FULL;
                                n_okey   = '0;
                                n_oval   = '0;
                            end
                            n_ofill = FILL_W'(n_count);
                        end
                        CMD_SEARCH, CMD_REMOVE: begin
                            n_state  = S_SCAN;
                            n_left   = r_count;
                            n_key    = i_key;
                            n_remove = (i_cmd == CMD_REMOVE);
                            n_found  = 1'b0;
                            n_fkey   = '0;
                            n_fval   = '0;
                        end
                        default: begin
                            n_valid  = 1'b1;
                            n_status = ST_MISSING;
                            n_okey   = '0;
                            n_oval   = '0;
                            n_ofill  = FILL_W'(r_count);
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_left == '0) begin
                    n_state  = S_IDLE;
                    n_valid  = 1'b1;
                    n_status = r_found ? ST_OK : ST_MISSING;
                    n_okey   = r_fkey;
                    n_oval   = r_fval;
                    n_ofill  = FILL_W'(r_count);
                end else begin
                    // The head entry leaves the chain and either wraps to the tail or,
                    // when it is the first match of a remove, is dropped.
                    o_pos       = r_count - 1'b1;
                    o_ctl.shift = 1'b1;
                    o_ctl.keep  = !(hit && r_remove);
                    n_left      = r_left - 1'b1;
                    if (hit) begin
                        n_found = 1'b1;
                        n_fkey  = i_head_key;
                        n_fval  = i_head_val;
                        if (r_remove) begin
                            n_count = r_count - 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left   <= n_left;
        r_key    <= n_key;
        r_remove <= n_remove;
        r_found  <= n_found;
        r_fkey   <= n_fkey;
        r_fval   <= n_fval;
        r_status <= n_status;
        r_okey   <= n_okey;
        r_oval   <= n_oval;
        r_ofill  <= n_ofill;
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_found_key   = r_okey;
    assign o_found_value = r_oval;
    assign o_fill_count  = r_ofill;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("fill count exceeds table depth");

    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_left <= r_count)
        else $error("scan steps left exceed ring length");

    a_insert_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_cmd == CMD_INSERT |=> r_valid)
        else $error("insert gave no result in the next cycle");

    a_scan_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN && r_left == '0 |=> r_valid && r_state == S_IDLE)
        else $error("finished scan gave no result");

endmodule

`default_nettype wire

@@ rtl/keyed_table_insert_search_remove.sv @@
`default_nettype none

// Keyed table of key/value entries kept in insertion order.
//
// A command (i_cmd, i_key, i_entry_value) transfers at a rising edge with start
// high and busy low. Insert appends the entry at the end of the table; search
// returns the first entry whose key matches; remove returns it and closes the
// gap so the remaining entries keep their order. Unknown command codes report
// a missing key and leave the table alone.
//
// Each command yields exactly one result, shown for one cycle with o_valid high;
// the receiver cannot stall it. Insert and unknown commands return their result
// in the next cycle; busy stays low, so one of these can transfer in every
// cycle. Search and remove rotate the table through the cell chain, examining
// the head cell once per cycle; busy is high while the scan runs and the result
// appears in the same cycle that busy falls. Scanning is serial because the
// chain has a single compare point at its head.
//
// Reset clears the fill count and the controller; entry storage is not cleared.
module keyed_table_insert_search_remove
    import kt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [1:0]              i_cmd,
    input  wire logic signed [KEY_W-1:0] i_key,
    input  wire logic [VAL_W-1:0]        i_entry_value,
    output logic                         o_valid,
    output logic [1:0]                   o_status,
    output logic signed [KEY_W-1:0]      o_found_key,
    output logic [VAL_W-1:0]             o_found_value,
    output logic [FILL_W-1:0]            o_fill_count
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_cell_ctl        ctl;
    logic [CW-1:0]    pos;
    logic [KEY_W-1:0] cell_key [TABLE_DEPTH];
    logic [VAL_W-1:0] cell_val [TABLE_DEPTH];
    logic [KEY_W-1:0] found_key;

    kt_ctrl #(
        .DEPTH (TABLE_DEPTH),
        .CW    (CW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_cmd         (i_cmd),
        .i_key         (i_key),
        .i_value       (i_entry_value),
        .i_head_key    (cell_key[0]),
        .i_head_val    (cell_val[0]),
        .o_busy        (busy),
        .o_ctl         (ctl),
        .o_pos         (pos),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_found_key   (found_key),
        .o_found_value (o_found_value),
        .o_fill_count  (o_fill_count)
    );

    assign o_found_key = found_key;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        // The last cell never takes from above; it is fed the head entry.
        localparam int NXT = (g + 1 < TABLE_DEPTH) ? g + 1 : 0;

        kt_cell #(
            .CW  (CW),
            .IDX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (ctl),
            .i_pos      (pos),
            .i_new_key  (i_key),
            .i_new_val  (i_entry_value),
            .i_next_key (cell_key[NXT]),
            .i_next_val (cell_val[NXT]),
            .i_head_key (cell_key[0]),
            .i_head_val (cell_val[0]),
            .o_key      (cell_key[g]),
            .o_val      (cell_val[g])
        );
    end

endmodule

`default_nettype wire
